FILE: rtl/trof_pkg.sv
// trof_pkg: sizes, codes, command/status types and helpers for the trace ring framer.
// No dependencies; imported by trof_ctrl, trof_dp and the top level.
package trof_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int LINE_LIMIT = 32;

	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int FILL_W     = $clog2(SLOT_COUNT + 1);
	localparam int LEN_W      = $clog2(LINE_LIMIT + 1);
	localparam int TEXT_DEPTH = SLOT_COUNT * LINE_LIMIT;
	localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
	localparam int STAMP_W    = 32;
	localparam int META_W     = LEN_W + STAMP_W;

	localparam int HDR_BYTES  = 6;
	localparam int HDR_IDX_W  = 3;

	localparam logic [7:0] FRAME_MARK = 8'hD1;
	localparam logic [7:0] CAP_RESET  = 8'hFF;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_BUILD  = 1'b1;

	// header byte positions
	localparam logic [HDR_IDX_W-1:0] HDR_MARK = 3'd0;
	localparam logic [HDR_IDX_W-1:0] HDR_SEQ  = 3'd1;
	localparam logic [HDR_IDX_W-1:0] HDR_TS0  = 3'd2;
	localparam logic [HDR_IDX_W-1:0] HDR_TS1  = 3'd3;
	localparam logic [HDR_IDX_W-1:0] HDR_TS2  = 3'd4;
	localparam logic [HDR_IDX_W-1:0] HDR_TS3  = 3'd5;

	typedef struct packed {
		logic                 append;   // accepted append item
		logic                 build;    // accepted build item with a line to frame
		logic                 latch;    // line metadata is on the meta RAM output
		logic                 emit;     // send one frame byte
		logic                 hdr_sel;  // byte comes from the header
		logic [HDR_IDX_W-1:0] hdr_idx;
		logic                 last;
		logic                 rd_en;    // text RAM read
		logic [LEN_W-1:0]     rd_idx;
	} trof_cmd_t;

	typedef struct packed {
		logic             can_build;
		logic [LEN_W-1:0] body_len;   // truncated text length of the frame in flight
	} trof_sts_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		next_slot = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

endpackage

FILE: rtl/trof_ram.sv
// trof_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module trof_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/trof_ctrl.sv
// trof_ctrl: accept logic and the frame sequencer (meta fetch, header, text).
// Depends on trof_pkg.
module trof_ctrl
	import trof_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      opcode,
	input  trof_sts_t sts,
	output logic      busy,
	output trof_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_META,
		ST_HDR,
		ST_TEXT
	} state_t;

	state_t               state_q;
	logic [HDR_IDX_W-1:0] hdr_cnt_q;
	logic [LEN_W-1:0]     txt_cnt_q;
	logic [LEN_W-1:0]     txt_next;
	logic                 accept;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign txt_next = txt_cnt_q + LEN_W'(1);

	always_comb begin
		cmd         = '0;
		cmd.append  = accept && (opcode == OP_APPEND);
		cmd.build   = accept && (opcode == OP_BUILD) && sts.can_build;
		cmd.hdr_idx = hdr_cnt_q;
		case (state_q)
			ST_META: begin
				cmd.latch = 1'b1;
			end
			ST_HDR: begin
				cmd.emit    = 1'b1;
				cmd.hdr_sel = 1'b1;
				cmd.last    = (hdr_cnt_q == HDR_TS3) && (sts.body_len == '0);
				cmd.rd_en   = 1'b1;   // primes text byte 0
				cmd.rd_idx  = '0;
			end
			ST_TEXT: begin
				cmd.emit   = 1'b1;
				cmd.last   = (txt_next == sts.body_len);
				cmd.rd_en  = !cmd.last;
				cmd.rd_idx = txt_next;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hdr_cnt_q <= '0;
			txt_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.build) begin
						state_q <= ST_META;
					end
				end
				ST_META: begin
					hdr_cnt_q <= HDR_MARK;
					state_q   <= ST_HDR;
				end
				ST_HDR: begin
					hdr_cnt_q <= hdr_cnt_q + HDR_IDX_W'(1);
					if (hdr_cnt_q == HDR_TS3) begin
						txt_cnt_q <= '0;
						state_q   <= (sts.body_len == '0) ? ST_IDLE : ST_TEXT;
					end
				end
				ST_TEXT: begin
					txt_cnt_q <= txt_next;
					if (cmd.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/trof_dp.sv
// trof_dp: ring pointers, line assembly, text and metadata RAMs, frame byte output register.
// Depends on trof_pkg and trof_ram.
module trof_dp
	import trof_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  trof_cmd_t          cmd,
	output trof_sts_t          sts,
	input  logic               frame_capacity_we,
	input  logic [7:0]         frame_capacity_wdata,
	input  logic [7:0]         text_byte,
	input  logic               byte_valid,
	input  logic               line_end,
	input  logic [STAMP_W-1:0] timestamp_ms,
	output logic               frame_valid,
	output logic [7:0]         frame_byte,
	output logic               frame_last
);

	logic [SLOT_W-1:0]  ws_q;
	logic [SLOT_W-1:0]  rs_q;
	logic [FILL_W-1:0]  fill_q;
	logic [7:0]         seq_q;
	logic [7:0]         cap_q;
	logic               open_q;
	logic [LEN_W-1:0]   olen_q;

	logic [TEXT_AW-1:0] base_q;
	logic [7:0]         fseq_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [LEN_W-1:0]   len_q;

	logic               valid_q;
	logic [7:0]         byte_q;
	logic               last_q;

	logic [LEN_W-1:0]   olen_cur;
	logic               byte_wr;
	logic [LEN_W-1:0]   olen_new;
	logic               drop;
	logic               commit;
	logic [TEXT_AW-1:0] text_waddr;
	logic [TEXT_AW-1:0] text_raddr;
	logic [7:0]         text_rdata;
	logic [META_W-1:0]  meta_rdata;
	logic [LEN_W-1:0]   meta_len;
	logic [7:0]         room;
	logic [LEN_W-1:0]   room_lim;
	logic [LEN_W-1:0]   frame_len;
	logic [7:0]         hdr_byte;

	// line assembly
	assign olen_cur   = open_q ? olen_q : '0;
	assign byte_wr    = cmd.append && byte_valid && (olen_cur < LEN_W'(LINE_LIMIT));
	assign olen_new   = byte_wr ? olen_cur + LEN_W'(1) : olen_cur;
	assign drop       = cmd.append && !open_q && (fill_q == FILL_W'(SLOT_COUNT));
	assign commit     = cmd.append && line_end;
	assign text_waddr = TEXT_AW'(TEXT_AW'(ws_q) * TEXT_AW'(LINE_LIMIT)) + TEXT_AW'(olen_cur);
	assign text_raddr = base_q + TEXT_AW'(cmd.rd_idx);

	trof_ram #(
		.WIDTH(8),
		.DEPTH(TEXT_DEPTH)
	) u_text_ram (
		.clk  (clk),
		.we   (byte_wr),
		.waddr(text_waddr),
		.wdata(text_byte),
		.re   (cmd.rd_en),
		.raddr(text_raddr),
		.rdata(text_rdata)
	);

	trof_ram #(
		.WIDTH(META_W),
		.DEPTH(SLOT_COUNT)
	) u_meta_ram (
		.clk  (clk),
		.we   (commit),
		.waddr(ws_q),
		.wdata({olen_new, timestamp_ms}),
		.re   (cmd.build),
		.raddr(rs_q),
		.rdata(meta_rdata)
	);

	// text length clipped to frame room; capacity >= header is checked at accept
	assign meta_len  = meta_rdata[META_W-1:STAMP_W];
	assign room      = cap_q - 8'(HDR_BYTES);
	assign room_lim  = (room > 8'(LINE_LIMIT)) ? LEN_W'(LINE_LIMIT) : LEN_W'(room);
	assign frame_len = (meta_len > room_lim) ? room_lim : meta_len;

	assign sts.can_build = (fill_q != '0) && (cap_q >= 8'(HDR_BYTES));
	assign sts.body_len  = len_q;

	always_comb begin
		case (cmd.hdr_idx)
			HDR_MARK: hdr_byte = FRAME_MARK;
			HDR_SEQ:  hdr_byte = fseq_q;
			HDR_TS0:  hdr_byte = stamp_q[7:0];
			HDR_TS1:  hdr_byte = stamp_q[15:8];
			HDR_TS2:  hdr_byte = stamp_q[23:16];
			HDR_TS3:  hdr_byte = stamp_q[31:24];
			default:  hdr_byte = FRAME_MARK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= '0;
			rs_q    <= '0;
			fill_q  <= '0;
			seq_q   <= '0;
			cap_q   <= CAP_RESET;
			open_q  <= 1'b0;
			olen_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (frame_capacity_we) begin
				cap_q <= frame_capacity_wdata;
			end
			if (cmd.append) begin
				open_q <= !line_end;
				olen_q <= line_end ? '0 : olen_new;
				if (commit) begin
					ws_q <= next_slot(ws_q);
				end
				// oldest line goes when a new line opens on a full ring
				if (drop) begin
					rs_q <= next_slot(rs_q);
				end
				if (drop && !commit) begin
					fill_q <= fill_q - FILL_W'(1);
				end else if (commit && !drop) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (cmd.build) begin
				rs_q   <= next_slot(rs_q);
				fill_q <= fill_q - FILL_W'(1);
				seq_q  <= seq_q + 8'd1;
			end
			valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build) begin
			base_q <= TEXT_AW'(TEXT_AW'(rs_q) * TEXT_AW'(LINE_LIMIT));
			fseq_q <= seq_q;
		end
		if (cmd.latch) begin
			stamp_q <= meta_rdata[STAMP_W-1:0];
			len_q   <= frame_len;
		end
		if (cmd.emit) begin
			byte_q <= cmd.hdr_sel ? hdr_byte : text_rdata;
			last_q <= cmd.last;
		end
	end

	assign frame_valid = valid_q;
	assign frame_byte  = byte_q;
	assign frame_last  = last_q;

endmodule

FILE: rtl/trace_ring_overwrite_framer.sv
// trace_ring_overwrite_framer: top level of the overwriting trace ring and frame builder.
// Depends on trof_pkg, trof_ctrl, trof_dp (and trof_ram below it).
//
//   channel   handshake                        payload
//   -------   ------------------------------   --------------------------------------
//   command   start & !busy                    opcode text_byte byte_valid line_end
//                                              timestamp_ms
//   frame     frame_valid                      frame_byte frame_last
//   config    frame_capacity_we                frame_capacity_wdata
//
// An append beat leaves busy low, so appends may come back to back.
// A build beat with a line to frame holds busy through a metadata RAM read, then the six
// header bytes and the text bytes, one frame byte per cycle, paced by the registered text RAM port.
// Frame bytes appear in the cycle after the sequencer emits them, on the output register.
// A build with nothing pending or capacity below 6 leaves busy low and emits nothing.
// Reset clears pointers, counters and the sequence number; the RAMs need no clearing.
// The receiver cannot stall: each frame beat is taken in the cycle it is shown.
module trace_ring_overwrite_framer
	import trof_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [7:0]         text_byte,
	input  logic               byte_valid,
	input  logic               line_end,
	input  logic [STAMP_W-1:0] timestamp_ms,
	input  logic               frame_capacity_we,
	input  logic [7:0]         frame_capacity_wdata,
	output logic               frame_valid,
	output logic [7:0]         frame_byte,
	output logic               frame_last
);

	trof_cmd_t cmd;
	trof_sts_t sts;

	trof_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(opcode),
		.sts   (sts),
		.busy  (busy),
		.cmd   (cmd)
	);

	trof_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.frame_capacity_we   (frame_capacity_we),
		.frame_capacity_wdata(frame_capacity_wdata),
		.text_byte           (text_byte),
		.byte_valid          (byte_valid),
		.line_end            (line_end),
		.timestamp_ms        (timestamp_ms),
		.frame_valid         (frame_valid),
		.frame_byte          (frame_byte),
		.frame_last          (frame_last)
	);

`ifndef SYNTHESIS
	// every frame beat comes out of a build in flight
	a_beat_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> $past(busy))
		else $error("frame beat without a build in flight");

	a_append_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_APPEND) |=> !frame_valid)
		else $error("append beat produced a frame beat");

	// frames are gap free up to the last beat
	a_frame_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !frame_last) |=> frame_valid)
		else $error("gap inside a frame");

	a_build_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.build |-> sts.can_build)
		else $error("build started with an empty ring or short capacity");
`endif

endmodule
